>>> rtl/lruk_pkg.sv
// ----------------------------------------------------------------------------
// lruk_pkg
// shared codes and defaults of the lru-k frame replacer
// ----------------------------------------------------------------------------
package lruk_pkg;

  localparam int unsigned FramesDef = 64;
  localparam int unsigned MaxKDef   = 8;
  localparam int unsigned StampW    = 48;

  localparam logic [2:0] ModeRecord = 3'd0;
  localparam logic [2:0] ModeEvict  = 3'd1;
  localparam logic [2:0] ModePin    = 3'd2;
  localparam logic [2:0] ModeRemove = 3'd3;
  localparam logic [2:0] ModeVictim = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StRange   = 2'd1;
  localparam logic [1:0] StPinned  = 2'd2;
  localparam logic [1:0] StNoVict  = 2'd3;

  localparam logic CfgFrames = 1'b0;
  localparam logic CfgDepth  = 1'b1;

endpackage

>>> rtl/lru_k_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer
// lru-k victim selector over buffer frames
// ----------------------------------------------------------------------------
// One result item per request item. Record access, mark and remove read the
// frame's history row, modify it, write it back and then give the result.
// Victim selection scans the history memory one frame a cycle. Tracked and
// evictable bits live in flip-flops; stamps and access counts live in one
// synchronous memory with one row per frame. Results leave through an output
// register, so the next request is taken as soon as the previous result has
// moved into it; a stalled result only holds up the result step of the
// following request.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer #(
  parameter int unsigned Frames = lruk_pkg::FramesDef,
  parameter int unsigned MaxK   = lruk_pkg::MaxKDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode_i,
  input  logic [6:0] frame_index_i,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status_o,
  output logic       victim_valid_o,
  output logic [5:0] victim_frame_o,
  output logic [6:0] evictable_count_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int unsigned SW   = lruk_pkg::StampW;
  localparam int unsigned FW   = $clog2(Frames);
  localparam int unsigned CW   = $clog2(Frames + 1);
  localparam int unsigned KW   = $clog2(MaxK + 1);
  localparam int unsigned RowW = (MaxK + 1) * SW + KW;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SMod   = 3'd2;
  localparam logic [2:0] SScan  = 3'd3;
  localparam logic [2:0] SPick  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0]  state_q;
  logic [Frames-1:0] trk_q, evb_q;
  logic [SW-1:0] aclk_q, eclk_q;
  logic [CW-1:0] etot_q;
  logic [6:0]  fiu_q;
  logic [3:0]  hd_q;
  logic [2:0]  mode_q;
  logic [FW-1:0] fr_q;
  logic [FW:0] scan_q;
  logic [FW-1:0] scan_f_q;
  logic        scan_v_q;
  logic        yf_q, of_q;
  logic [FW-1:0] yid_q, oid_q;
  logic [SW-1:0] yb_q, ob_q;
  logic [1:0]  st_q;
  logic        vv_q;
  logic [FW-1:0] vf_q;
  logic        ov_q;
  logic [1:0]  ost_q;
  logic        ovv_q;
  logic [5:0]  ovf_q;
  logic [6:0]  ocnt_q;

  logic          we;
  logic [FW-1:0] waddr, raddr;
  logic [RowW-1:0] wdata, rdata;
  logic [KW-1:0] keff;

  lruk_stamp_mem #(.Frames(Frames), .MaxK(MaxK)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // effective k, clamped to 1..MaxK
  always_comb begin
    if (hd_q == 4'd0) keff = KW'(1);
    else if (32'(hd_q) > MaxK) keff = KW'(MaxK);
    else keff = KW'(hd_q);
  end

  logic out_load;
  assign out_load = (state_q == SOut) && (!ov_q || !out_stall);

  assign in_stall  = (state_q != SIdle);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_q;
  assign status_o  = ost_q;
  assign victim_valid_o = ovv_q;
  assign victim_frame_o = ovf_q;
  assign evictable_count_o = ocnt_q;

  logic acc;
  logic in_range;
  assign acc = in_valid && !in_stall;
  assign in_range = (32'(frame_index_i) < Frames) &&
                    (frame_index_i < fiu_q);

  assign raddr = (state_q == SScan) ? scan_q[FW-1:0] : fr_q;

  // access count held in the row read back
  logic [KW-1:0] cnt_r, cnt_new;
  assign cnt_r = rdata[MaxK*SW +: KW];
  always_comb begin
    if (!trk_q[fr_q]) cnt_new = KW'(1);
    else if (32'(cnt_r) < MaxK) cnt_new = cnt_r + KW'(1);
    else cnt_new = cnt_r;
  end

  // modified row for the addressed frame
  logic [SW-1:0] newstamp;
  assign newstamp = aclk_q + SW'(1);
  always_comb begin
    wdata = rdata;
    we    = 1'b0;
    waddr = fr_q;
    if (state_q == SMod) begin
      if (mode_q == lruk_pkg::ModeRecord) begin
        we = 1'b1;
        wdata[MaxK*SW-1:0] = {rdata[(MaxK-1)*SW-1:0], newstamp} >> 0;
        if (!trk_q[fr_q]) wdata[SW-1:0] = newstamp;
        wdata[MaxK*SW +: KW] = cnt_new;
      end else if (mode_q == lruk_pkg::ModeEvict && trk_q[fr_q] && !evb_q[fr_q]) begin
        we = 1'b1;
        wdata[RowW-1 -: SW] = eclk_q + SW'(1);
      end
    end
  end

  // candidate data from the scanned row
  logic [SW-1:0] ent_s, dist_s;
  logic cand, young;
  assign ent_s  = rdata[RowW-1 -: SW];
  assign dist_s = rdata[(32'(keff)-1)*SW +: SW];
  assign cand   = scan_v_q && trk_q[scan_f_q] && evb_q[scan_f_q];
  assign young  = cnt_r < keff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      trk_q <= '0; evb_q <= '0;
      aclk_q <= '0; eclk_q <= '0; etot_q <= '0;
      fiu_q <= 7'd64; hd_q <= 4'd2;
      ov_q <= 1'b0; scan_v_q <= 1'b0; scan_q <= '0;
      yf_q <= 1'b0; of_q <= 1'b0;
      ost_q <= lruk_pkg::StOk; ovv_q <= 1'b0; ovf_q <= '0; ocnt_q <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lruk_pkg::CfgFrames) fiu_q <= cfg_data;
        else hd_q <= cfg_data[3:0];
      end
      // output register
      if (out_load) begin
        ov_q <= 1'b1;
        ost_q <= st_q; ovv_q <= vv_q; ovf_q <= 6'(vf_q); ocnt_q <= 7'(etot_q);
      end else if (!out_stall) ov_q <= 1'b0;
      unique case (state_q)
        SIdle: if (acc) begin
          mode_q <= mode_i;
          fr_q <= FW'(frame_index_i);
          st_q <= lruk_pkg::StOk; vv_q <= 1'b0; vf_q <= '0;
          if (mode_i <= lruk_pkg::ModeRemove) begin
            if (!in_range) begin
              st_q <= lruk_pkg::StRange; state_q <= SOut;
            end else state_q <= SRead;
          end else if (mode_i == lruk_pkg::ModeVictim) begin
            if (etot_q == '0) begin
              st_q <= lruk_pkg::StNoVict; state_q <= SOut;
            end else begin
              state_q <= SScan; scan_q <= '0; scan_v_q <= 1'b0;
              yf_q <= 1'b0; of_q <= 1'b0;
            end
          end else state_q <= SOut;
        end
        SRead: state_q <= SMod;
        SMod: begin
          state_q <= SOut;
          unique case (mode_q)
            lruk_pkg::ModeRecord: begin
              aclk_q <= newstamp;
              trk_q[fr_q] <= 1'b1;
              if (!trk_q[fr_q]) evb_q[fr_q] <= 1'b0;
            end
            lruk_pkg::ModeEvict: if (trk_q[fr_q] && !evb_q[fr_q]) begin
              evb_q[fr_q] <= 1'b1; eclk_q <= eclk_q + SW'(1);
              etot_q <= etot_q + CW'(1);
            end
            lruk_pkg::ModePin: if (trk_q[fr_q] && evb_q[fr_q]) begin
              evb_q[fr_q] <= 1'b0;
              if (etot_q != '0) etot_q <= etot_q - CW'(1);
            end
            default: if (trk_q[fr_q]) begin
              if (!evb_q[fr_q]) st_q <= lruk_pkg::StPinned;
              else begin
                trk_q[fr_q] <= 1'b0; evb_q[fr_q] <= 1'b0;
                if (etot_q != '0) etot_q <= etot_q - CW'(1);
              end
            end
          endcase
        end
        SScan: begin
          // issue next address, evaluate previous row
          scan_v_q <= (32'(scan_q) < Frames);
          scan_f_q <= scan_q[FW-1:0];
          if (32'(scan_q) < Frames) scan_q <= scan_q + (FW+1)'(1);
          if (cand) begin
            if (young) begin
              if (!yf_q || ent_s < yb_q) begin
                yf_q <= 1'b1; yid_q <= scan_f_q; yb_q <= ent_s;
              end
            end else if (!of_q || dist_s < ob_q) begin
              of_q <= 1'b1; oid_q <= scan_f_q; ob_q <= dist_s;
            end
          end
          if (scan_v_q && 32'(scan_f_q) == Frames - 1) state_q <= SPick;
        end
        SPick: begin
          state_q <= SOut;
          if (yf_q || of_q) begin
            vf_q <= yf_q ? yid_q : oid_q; vv_q <= 1'b1;
            trk_q[yf_q ? yid_q : oid_q] <= 1'b0;
            evb_q[yf_q ? yid_q : oid_q] <= 1'b0;
            if (etot_q != '0) etot_q <= etot_q - CW'(1);
          end else st_q <= lruk_pkg::StNoVict;
        end
        SOut: if (out_load) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  // checks
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> in_stall) else $error("accept while busy");
  a_victim_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && victim_valid_o) |-> (status_o == lruk_pkg::StOk))
    else $error("victim with error status");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(etot_q) <= Frames) else $error("evictable count overflow");

endmodule

>>> rtl/lruk_stamp_mem.sv
// ----------------------------------------------------------------------------
// lruk_stamp_mem
// per-frame history rows: MAX_K stamps newest first, the access count and the
// evictable-entry stamp
// ----------------------------------------------------------------------------
module lruk_stamp_mem #(
  parameter int unsigned Frames = lruk_pkg::FramesDef,
  parameter int unsigned MaxK   = lruk_pkg::MaxKDef,
  localparam int unsigned FW    = $clog2(Frames),
  localparam int unsigned RowW  = (MaxK + 1) * lruk_pkg::StampW + $clog2(MaxK + 1)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [FW-1:0]   waddr_i,
  input  logic [RowW-1:0] wdata_i,
  input  logic [FW-1:0]   raddr_i,
  output logic [RowW-1:0] rdata_o
);

  logic [RowW-1:0] mem [Frames];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru-k frame replacer: requests go through a
// stall handshake, each result is compared with an in-bench replacer model
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumFrames = 64;
  localparam int unsigned DepthMax  = 8;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [2:0] ModeSpareLo  = 3'd5;
  localparam logic [2:0] ModeSpareMid = 3'd6;
  localparam logic [2:0] ModeSpareHi  = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic       victim_valid;
    logic [5:0] victim_frame;
    logic [6:0] evictable_count;
  } reply_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] mode_i;
  logic [6:0] frame_index_i;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status_o;
  logic       victim_valid_o;
  logic [5:0] victim_frame_o;
  logic [6:0] evictable_count_o;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;

  lru_k_frame_replacer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode_i           (mode_i),
    .frame_index_i    (frame_index_i),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status_o         (status_o),
    .victim_valid_o   (victim_valid_o),
    .victim_frame_o   (victim_frame_o),
    .evictable_count_o(evictable_count_o),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // replacer model state
  logic        frame_tracked [NumFrames];
  logic        frame_evictable [NumFrames];
  int unsigned frame_hits [NumFrames];
  logic [47:0] hit_stamps [NumFrames][DepthMax];
  logic [47:0] entry_stamp [NumFrames];
  logic [47:0] hit_clock;
  logic [47:0] entry_count_clock;
  int unsigned evictable_frames;
  int unsigned frames_limit;
  int unsigned depth_reg;

  reply_t pending_replies[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // clamped history depth and frame limit
  function automatic int unsigned depth_eff();
    if (depth_reg < 1) return 1;
    if (depth_reg > DepthMax) return DepthMax;
    return depth_reg;
  endfunction

  function automatic int unsigned limit_eff();
    return (frames_limit > NumFrames) ? NumFrames : frames_limit;
  endfunction

  task automatic model_reset();
    for (int f = 0; f < NumFrames; f++) begin
      frame_tracked[f]   = 1'b0;
      frame_evictable[f] = 1'b0;
      frame_hits[f]      = 0;
    end
    hit_clock         = '0;
    entry_count_clock = '0;
    evictable_frames  = 0;
    frames_limit      = 64;
    depth_reg         = 2;
  endtask

  task automatic drop_frame(input int f);
    frame_tracked[f]   = 1'b0;
    frame_evictable[f] = 1'b0;
    frame_hits[f]      = 0;
    if (evictable_frames > 0) evictable_frames--;
  endtask

  // pick victim: young frames by entry order first, else oldest k-th stamp
  function automatic int choose_victim();
    int young;
    int old;
    logic [47:0] young_best;
    logic [47:0] old_best;
    int unsigned k;
    young = -1;
    old = -1;
    young_best = '0;
    old_best = '0;
    k = depth_eff();
    for (int f = 0; f < NumFrames; f++) begin
      if (frame_tracked[f] && frame_evictable[f]) begin
        if (frame_hits[f] < k) begin
          if (young < 0 || entry_stamp[f] < young_best) begin
            young = f;
            young_best = entry_stamp[f];
          end
        end else if (old < 0 || hit_stamps[f][k-1] < old_best) begin
          old = f;
          old_best = hit_stamps[f][k-1];
        end
      end
    end
    return (young >= 0) ? young : old;
  endfunction

  // apply one request to the model and return its reply
  task automatic predict_reply(input logic [2:0] mode, input logic [6:0] idx,
                               output reply_t rep);
    int v;
    int f;
    rep = '0;
    f = idx;
    if (mode <= lruk_pkg::ModeRemove) begin
      if (idx >= limit_eff()) begin
        rep.status = lruk_pkg::StRange;
      end else begin
        case (mode)
          lruk_pkg::ModeRecord: begin
            hit_clock = hit_clock + 48'd1;
            if (!frame_tracked[f]) begin
              frame_tracked[f]   = 1'b1;
              frame_evictable[f] = 1'b0;
              frame_hits[f]      = 1;
            end else begin
              for (int i = DepthMax - 1; i > 0; i--) hit_stamps[f][i] = hit_stamps[f][i-1];
              if (frame_hits[f] < DepthMax) frame_hits[f]++;
            end
            hit_stamps[f][0] = hit_clock;
          end
          lruk_pkg::ModeEvict: begin
            if (frame_tracked[f] && !frame_evictable[f]) begin
              frame_evictable[f] = 1'b1;
              entry_count_clock = entry_count_clock + 48'd1;
              entry_stamp[f] = entry_count_clock;
              evictable_frames++;
            end
          end
          lruk_pkg::ModePin: begin
            if (frame_tracked[f] && frame_evictable[f]) begin
              frame_evictable[f] = 1'b0;
              if (evictable_frames > 0) evictable_frames--;
            end
          end
          default: begin
            if (frame_tracked[f]) begin
              if (!frame_evictable[f]) rep.status = lruk_pkg::StPinned;
              else drop_frame(f);
            end
          end
        endcase
      end
    end else if (mode == lruk_pkg::ModeVictim) begin
      v = (evictable_frames == 0) ? -1 : choose_victim();
      if (v < 0) begin
        rep.status = lruk_pkg::StNoVict;
      end else begin
        drop_frame(v);
        rep.victim_valid = 1'b1;
        rep.victim_frame = v[5:0];
      end
    end
    rep.evictable_count = evictable_frames[6:0];
  endtask

  // send one request item, predict it once accepted
  task automatic send_request(input logic [2:0] mode, input logic [6:0] idx);
    reply_t rep;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid      = 1'b1;
    mode_i        = mode;
    frame_index_i = idx;
    do @(posedge clk_i); while (in_stall);
    predict_reply(mode, idx, rep);
    pending_replies.push_back(rep);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic drain_replies();
    stop_sending();
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic idx, input logic [6:0] data);
    drain_replies();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == lruk_pkg::CfgFrames) frames_limit = data;
    else depth_reg = data[3:0];
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // mostly in-range frames, a few anywhere in the field
  function automatic logic [6:0] pick_frame();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, limit_eff() - 1));
  endfunction

  function automatic logic [2:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return lruk_pkg::ModeRecord;
    if (r < 60) return lruk_pkg::ModeEvict;
    if (r < 70) return lruk_pkg::ModePin;
    if (r < 80) return lruk_pkg::ModeRemove;
    if (r < 95) return lruk_pkg::ModeVictim;
    return 3'($urandom_range(ModeSpareLo, ModeSpareHi));
  endfunction

  task automatic send_random(input int unsigned count);
    for (int n = 0; n < count; n++) send_request(pick_mode(), pick_frame());
  endtask

  // extremes, each mode and the named corner cases
  task automatic test_directed();
    send_request(lruk_pkg::ModeVictim, 7'd0);        // empty evict
    send_request(lruk_pkg::ModeEvict, 7'd5);         // untracked targets
    send_request(lruk_pkg::ModePin, 7'd5);
    send_request(lruk_pkg::ModeRemove, 7'd5);
    send_request(lruk_pkg::ModeRecord, 7'd127);      // out of range
    send_request(lruk_pkg::ModeRecord, 7'd64);
    send_request(lruk_pkg::ModeRecord, 7'd63);       // first access
    send_request(lruk_pkg::ModeRecord, 7'd0);
    send_request(lruk_pkg::ModeRecord, 7'd0);
    send_request(lruk_pkg::ModeRemove, 7'd63);       // remove of pinned frame
    send_request(lruk_pkg::ModeEvict, 7'd63);
    send_request(lruk_pkg::ModeEvict, 7'd63);        // already evictable
    send_request(lruk_pkg::ModeEvict, 7'd0);
    send_request(lruk_pkg::ModePin, 7'd0);
    send_request(lruk_pkg::ModePin, 7'd0);           // already pinned
    send_request(lruk_pkg::ModeEvict, 7'd0);
    send_request(ModeSpareLo, 7'd85);
    send_request(ModeSpareMid, 7'd42);
    send_request(ModeSpareHi, 7'd127);
    send_request(lruk_pkg::ModeVictim, 7'd127);      // young frame wins
    send_request(lruk_pkg::ModeRemove, 7'd0);
    send_request(lruk_pkg::ModeVictim, 7'd0);
  endtask

  // several register settings, the extremes among them
  task automatic test_config_sweep();
    write_reg(lruk_pkg::CfgDepth, 7'd1);
    send_random(30);
    write_reg(lruk_pkg::CfgFrames, 7'd1);
    send_random(20);
    write_reg(lruk_pkg::CfgDepth, 7'd0);             // depth zero acts as one
    write_reg(lruk_pkg::CfgFrames, 7'd16);
    send_random(40);
    write_reg(lruk_pkg::CfgDepth, 7'd15);            // above max acts as max
    write_reg(lruk_pkg::CfgFrames, 7'd127);          // capped at the frame count
    send_random(40);
    write_reg(lruk_pkg::CfgDepth, 7'd8);
    write_reg(lruk_pkg::CfgFrames, 7'd8);            // shrunk range, high frames stay
    send_random(30);
    write_reg(lruk_pkg::CfgFrames, 7'd64);
    write_reg(lruk_pkg::CfgDepth, 7'd3);
  endtask

  // random traffic under each idling mix
  task automatic test_random_phases();
    send_idle_pct = 18;
    recv_idle_pct = 81;
    send_random(90);
    send_idle_pct = 81;
    recv_idle_pct = 18;
    send_random(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(90);
  endtask

  // long receiver hold-off while items keep coming
  task automatic test_backpressure();
    hold_left = 400;
    send_random(30);
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    reply_t exp_rep;
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("result item with no request waiting");
          fail_count++;
        end else begin
          exp_rep = pending_replies[0];
          pending_replies.delete(0);
          if (status_o !== exp_rep.status) begin
            $error("status: expected %0d, got %0d", exp_rep.status, status_o);
            fail_count++;
          end
          if (victim_valid_o !== exp_rep.victim_valid) begin
            $error("victim_valid: expected %0d, got %0d", exp_rep.victim_valid,
                   victim_valid_o);
            fail_count++;
          end
          if (victim_frame_o !== exp_rep.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", exp_rep.victim_frame,
                   victim_frame_o);
            fail_count++;
          end
          if (evictable_count_o !== exp_rep.evictable_count) begin
            $error("evictable_count: expected %0d, got %0d", exp_rep.evictable_count,
                   evictable_count_o);
            fail_count++;
          end
        end
      end
    end
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    mode_i        = lruk_pkg::ModeRecord;
    frame_index_i = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = lruk_pkg::CfgFrames;
    cfg_data      = '0;
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    model_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 81;
    test_directed();
    test_config_sweep();
    test_random_phases();
    test_backpressure();

    drain_replies();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
